// ===== rtl/core/dfh_pkg.sv =====
// dfh_pkg: shared types, constants and bit helpers for the fixed-Huffman
// symbol encoder. No dependencies; used by the interfaces and all modules.
`timescale 1ns / 1ps
`default_nettype none

package dfh_pkg;

  localparam logic [8:0]  LIT_MAX_SYM = 9'd285;
  localparam logic [7:0]  LEN_MAX_VAL = 8'd255;
  localparam logic [15:0] DIST_MAX    = 16'd32768;
  localparam logic [8:0]  LEN_CODE_BASE = 9'd257;
  localparam logic [8:0]  LEN_CODE_MAX  = 9'd285;
  localparam logic [2:0]  DIST_CODE_LEN = 3'd5;

  typedef struct packed {
    logic [8:0]  lit_or_len;
    logic [15:0] dist_req;
  } sym_t;

  typedef struct packed {
    logic [8:0]  lit_code;
    logic [3:0]  lit_code_len;
    logic [4:0]  len_extra;
    logic [2:0]  len_extra_len;
    logic [4:0]  dist_code;
    logic [2:0]  dist_code_len;
    logic [12:0] dist_extra;
    logic [3:0]  dist_extra_len;
    logic [4:0]  total_bits;
  } enc_t;

  // index of the highest set bit, 0 for a zero word
  function automatic logic [3:0] top_bit15(input logic [14:0] v);
    logic [3:0] b;
    b = 4'd0;
    for (int i = 0; i < 15; i++) begin
      if (v[i]) begin
        b = 4'(i);
      end
    end
    return b;
  endfunction

  function automatic logic [8:0] rev9(input logic [8:0] v);
    logic [8:0] r;
    for (int i = 0; i < 9; i++) begin
      r[i] = v[8 - i];
    end
    return r;
  endfunction

  function automatic logic [4:0] rev5(input logic [4:0] v);
    logic [4:0] r;
    for (int i = 0; i < 5; i++) begin
      r[i] = v[4 - i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dfh_sym_if.sv =====
// dfh_sym_if: valid/ready channel carrying one input symbol transaction.
// Depends on dfh_pkg for the payload type.
`timescale 1ns / 1ps
`default_nettype none

interface dfh_sym_if;
  logic          valid;
  logic          ready;
  dfh_pkg::sym_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dfh_enc_if.sv =====
// dfh_enc_if: valid/ready channel carrying one encoded symbol transaction.
// Depends on dfh_pkg for the payload type.
`timescale 1ns / 1ps
`default_nettype none

interface dfh_enc_if;
  logic          valid;
  logic          ready;
  dfh_pkg::enc_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dfh_huff_code.sv =====
// dfh_huff_code: fixed literal/length Huffman code lookup, bit-reversed.
// Depends on dfh_pkg (rev9).
`timescale 1ns / 1ps
`default_nettype none

module dfh_huff_code (
  input  wire logic [8:0] code,
  output logic      [8:0] lit_code,
  output logic      [3:0] lit_code_len
);

  logic [8:0] canon;

  always_comb begin
    priority if (code < 9'd144) begin
      lit_code_len = 4'd8;
      canon        = 9'h030 + code;
    end else if (code < 9'd256) begin
      lit_code_len = 4'd9;
      canon        = 9'h190 + (code - 9'd144);
    end else if (code < 9'd280) begin
      lit_code_len = 4'd7;
      canon        = code - 9'd256;
    end else begin
      lit_code_len = 4'd8;
      canon        = 9'h0C0 + (code - 9'd280);
    end
  end

  // reverse as 9 bits, then drop the unused low bits of shorter codes
  assign lit_code = dfh_pkg::rev9(canon) >> (4'd9 - lit_code_len);

endmodule

`default_nettype wire

// ===== rtl/core/deflate_fixed_huffman_symbol_encoder_core.sv =====
// deflate_fixed_huffman_symbol_encoder_core: three-stage pipelined encoder.
// Depends on dfh_pkg, dfh_sym_if, dfh_enc_if and dfh_huff_code.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   symbols : sink channel, one transaction per symbol. dist_req == 0 means
//             lit_or_len is a literal / end-of-block symbol, else it is a
//             match length minus three with distance dist_req.
//   codes   : source channel, one transaction per symbol with the
//             bit-reversed fixed Huffman code, extra bits, widths and the
//             total bit count.
// Pipeline: three register stages (saturate + highest-bit search,
//   code/extra-bit mapping, Huffman lookup and bit reversal into the
//   output register) lie between an accepted symbol and the output
//   register from which its code can be taken.
// Throughput: 1 symbol per cycle while the pipe is not stalled; stage 1 holds
//   both highest-bit searches, stage 2 the code mapping with its extra-bit
//   shifts, stage 3 the Huffman range lookup.
// Reset: synchronous rst clears every stage valid; the pipe comes up empty
//   and symbols.ready is high.
// Stall: when codes.ready is low with a result waiting, the whole pipe
//   holds (symbols.ready drops); nothing is lost or repeated, and the pipe
//   resumes the same cycle codes.ready returns.

module deflate_fixed_huffman_symbol_encoder_core (
  input wire logic clk,
  input wire logic rst,
  dfh_sym_if.sink   symbols,
  dfh_enc_if.source codes
);

  // global advance: output register empty or being taken
  logic advance;

  // ---------------- stage 1: saturate, find top bits ----------------
  logic        s1_valid;
  logic        s1_lit;
  logic [8:0]  s1_sym;     // saturated literal symbol
  logic [7:0]  s1_len;     // saturated length value
  logic [2:0]  s1_len_top;
  logic [14:0] s1_dv;      // distance minus one
  logic [3:0]  s1_dv_top;

  logic [15:0] d_sat;
  logic [14:0] dv_c;
  logic [7:0]  len_c;
  logic [3:0]  len_top_w;

  always_comb begin
    d_sat     = (symbols.data.dist_req > dfh_pkg::DIST_MAX) ? dfh_pkg::DIST_MAX
                                                           : symbols.data.dist_req;
    dv_c      = 15'(d_sat - 16'd1);
    len_c     = (symbols.data.lit_or_len > 9'(dfh_pkg::LEN_MAX_VAL))
                ? dfh_pkg::LEN_MAX_VAL : symbols.data.lit_or_len[7:0];
    len_top_w = dfh_pkg::top_bit15({7'd0, len_c});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= symbols.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_lit     <= (symbols.data.dist_req == 16'd0);
      s1_sym     <= (symbols.data.lit_or_len > dfh_pkg::LIT_MAX_SYM)
                    ? dfh_pkg::LIT_MAX_SYM : symbols.data.lit_or_len;
      s1_len     <= len_c;
      s1_len_top <= len_top_w[2:0];
      s1_dv      <= dv_c;
      s1_dv_top  <= dfh_pkg::top_bit15(dv_c);
    end
  end

  // ---------------- stage 2: code numbers and extra bits ----------------
  logic        s2_valid;
  logic [8:0]  s2_code;
  logic [4:0]  s2_lx;
  logic [2:0]  s2_lxl;
  logic [4:0]  s2_dcode;
  logic [2:0]  s2_dcl;
  logic [12:0] s2_dx;
  logic [3:0]  s2_dxl;

  logic [8:0]  code_c;
  logic [4:0]  lx_c;
  logic [2:0]  lxl_c;
  logic [4:0]  dcode_c;
  logic [2:0]  dcl_c;
  logic [12:0] dx_c;
  logic [3:0]  dxl_c;
  logic [7:0]  len_sh;
  logic [14:0] dv_sh;

  always_comb begin
    lxl_c   = 3'd0;
    lx_c    = 5'd0;
    dxl_c   = 4'd0;
    dx_c    = 13'd0;
    dcode_c = 5'd0;
    dcl_c   = 3'd0;
    len_sh  = 8'd0;
    dv_sh   = 15'd0;
    if (s1_lit) begin
      code_c = s1_sym;
    end else begin
      // length symbol
      priority if (s1_len == dfh_pkg::LEN_MAX_VAL) begin
        code_c = dfh_pkg::LEN_CODE_MAX;
      end else if (s1_len < 8'd8) begin
        code_c = dfh_pkg::LEN_CODE_BASE + {1'b0, s1_len};
      end else begin
        lxl_c  = s1_len_top - 3'd2;
        len_sh = s1_len >> lxl_c;
        code_c = dfh_pkg::LEN_CODE_BASE + {4'd0, s1_len_top - 3'd1, len_sh[1:0]};
        lx_c   = 5'(s1_len & ((8'd1 << lxl_c) - 8'd1));
      end
      // distance symbol: two codes per power of two from four up
      if (s1_dv < 15'd4) begin
        dcode_c = 5'(s1_dv);
      end else begin
        dxl_c   = s1_dv_top - 4'd1;
        dv_sh   = s1_dv >> dxl_c;
        dcode_c = {s1_dv_top, dv_sh[0]};
        dx_c    = 13'(s1_dv & ((15'd1 << dxl_c) - 15'd1));
      end
      dcl_c = dfh_pkg::DIST_CODE_LEN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_code  <= code_c;
      s2_lx    <= lx_c;
      s2_lxl   <= lxl_c;
      s2_dcode <= dcode_c;
      s2_dcl   <= dcl_c;
      s2_dx    <= dx_c;
      s2_dxl   <= dxl_c;
    end
  end

  // ---------------- stage 3: Huffman lookup into output register ----------
  logic       s3_valid;
  logic [8:0] lit_code_c;
  logic [3:0] clen_c;

  dfh_huff_code u_huff (
    .code         (s2_code),
    .lit_code     (lit_code_c),
    .lit_code_len (clen_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      codes.data.lit_code       <= lit_code_c;
      codes.data.lit_code_len   <= clen_c;
      codes.data.len_extra      <= s2_lx;
      codes.data.len_extra_len  <= s2_lxl;
      codes.data.dist_code      <= dfh_pkg::rev5(s2_dcode);
      codes.data.dist_code_len  <= s2_dcl;
      codes.data.dist_extra     <= s2_dx;
      codes.data.dist_extra_len <= s2_dxl;
      codes.data.total_bits     <= {1'b0, clen_c} + {2'd0, s2_lxl}
                                   + {2'd0, s2_dcl} + {1'b0, s2_dxl};
    end
  end

  assign advance       = !s3_valid || codes.ready;
  assign symbols.ready = advance;
  assign codes.valid   = s3_valid;

endmodule

`default_nettype wire
